@@ sv/assert_macros.svh @@
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_NEVER(lbl, clk, rst, expr)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ sv/cbte_pkg.sv @@
package cbte_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int POS_W           = 32;
   localparam int DIR_W           = 16;
   localparam int T_W             = 17;
   localparam int OUT_W           = 32;
   localparam int DIR_FRAC        = 14;
   localparam int T_FRAC          = 16;
   localparam int QUEUE_DEPTH     = 2;

   localparam logic [T_W-1:0] T_ONE = T_W'(65536);

   localparam logic [1:0] CMD_LOAD_START = 2'd0;
   localparam logic [1:0] CMD_LOAD_END   = 2'd1;
   localparam logic [1:0] CMD_EVAL       = 2'd2;

   // effective coordinate width: clamp to 16..32
   function automatic int eff_width(input int cw);
      return (cw < 16) ? 16 : ((cw > 32) ? 32 : cw);
   endfunction

   typedef struct packed {
      logic [1:0]                  cmd;
      logic [2:0][POS_W-1:0]       pos;
      logic [2:0][DIR_W-1:0]       dir;
      logic [T_W-1:0]              t;
   } work_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

@@ sv/cbte_front.sv @@
module cbte_front
   import cbte_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic                    start,
   output logic                    busy,
   input  logic [1:0]              req_command,
   input  logic signed [POS_W-1:0] req_pos_x,
   input  logic signed [POS_W-1:0] req_pos_y,
   input  logic signed [POS_W-1:0] req_pos_z,
   input  logic signed [DIR_W-1:0] req_dir_x,
   input  logic signed [DIR_W-1:0] req_dir_y,
   input  logic signed [DIR_W-1:0] req_dir_z,
   input  logic [T_W-1:0]          req_curve_t,
   input  qstat_type               qstat,
   output logic                    push,
   output work_type                push_item
);

   localparam int W = eff_width(COORD_WIDTH);

   // wrap a location into the effective width
   function automatic logic [POS_W-1:0] fit(input logic [POS_W-1:0] v);
      logic signed [W-1:0] low;
      low = v[W-1:0];
      return POS_W'(low);
   endfunction

   logic cmd_known;

   always_comb begin
      cmd_known = req_command inside {CMD_LOAD_START, CMD_LOAD_END, CMD_EVAL};
      busy      = qstat.full;
      push      = start && !qstat.full && cmd_known;

      push_item.cmd    = req_command;
      push_item.pos[0] = fit(req_pos_x);
      push_item.pos[1] = fit(req_pos_y);
      push_item.pos[2] = fit(req_pos_z);
      push_item.dir[0] = req_dir_x;
      push_item.dir[1] = req_dir_y;
      push_item.dir[2] = req_dir_z;
      push_item.t      = (req_curve_t > T_ONE) ? T_ONE : req_curve_t;
   end

endmodule

@@ sv/cbte_queue.sv @@
`include "assert_macros.svh"

module cbte_queue
   import cbte_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  work_type  push_item,
   input  logic      pop,
   output work_type  pop_item,
   output qstat_type qstat
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   work_type       mem_ff [QUEUE_DEPTH];
   logic [PW-1:0]  wr_ff, wr_in;
   logic [PW-1:0]  rd_ff, rd_in;
   logic [PW:0]    cnt_ff, cnt_in;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
      qstat.full  = (cnt_ff == (PW+1)'(QUEUE_DEPTH));
      qstat.empty = (cnt_ff == '0);
      pop_item    = mem_ff[rd_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end

   `ASSERT_NEVER(a_push_full, clock, reset, push && qstat.full)
   `ASSERT_NEVER(a_pop_empty, clock, reset, pop && qstat.empty)
   `ASSERT_NEVER(a_cnt_range, clock, reset, cnt_ff > (PW+1)'(QUEUE_DEPTH))

endmodule

@@ sv/cbte_back.sv @@
`include "assert_macros.svh"

module cbte_back
   import cbte_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  qstat_type        qstat,
   input  work_type         pop_item,
   output logic             pop,
   output logic             out_valid,
   output logic [OUT_W-1:0] out_point [3],
   output logic [OUT_W-1:0] out_slope [3]
);

   localparam int W    = eff_width(COORD_WIDTH);
   localparam int S    = (W > 31) ? W - 31 : 0;
   localparam int MW   = W + 1 - S;
   localparam int SW   = 2 * MW + 2;
   localparam int RW   = MW + 1;
   localparam int LW   = RW + S + 1;
   localparam int HW   = W;
   localparam int IW   = W + 2;
   localparam int DW   = IW + 1;
   localparam int HPW  = DIR_W + HW + 2;
   localparam int LPW  = DW + T_W + 1;
   localparam int PRW  = (HPW > LPW) ? HPW : LPW;
   localparam int SATW = DW + 2;
   localparam int ITW  = $clog2(RW);

   localparam logic [PRW-1:0] HALF_DIR = PRW'(1) << (DIR_FRAC - 1);
   localparam logic [PRW-1:0] HALF_T   = PRW'(1) << (T_FRAC - 1);
   localparam logic [2:0]     STEP_P2  = 3'd1;
   localparam logic [2:0]     STEP_LAST = 3'd7;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SQUARE = 5'b00010,
      ST_ROOT   = 5'b00100,
      ST_SCALE  = 5'b01000,
      ST_CURVE  = 5'b10000
   } state_type;

   // de Casteljau: left operand index of each lerp step
   function automatic logic [1:0] lerp_idx(input logic [2:0] step);
      logic [1:0] j;
      case (step)
         3'd3:    j = 2'd1;
         3'd4:    j = 2'd2;
         3'd6:    j = 2'd1;
         default: j = 2'd0;
      endcase
      return j;
   endfunction

   function automatic logic [OUT_W-1:0] sat_out(input logic signed [SATW-1:0] v);
      logic signed [SATW-1:0] hi;
      logic signed [SATW-1:0] lo;
      logic signed [SATW-1:0] r;
      logic signed [W-1:0]    n;
      hi = {{(SATW-W+1){1'b0}}, {(W-1){1'b1}}};
      lo = ~hi;
      r  = (v > hi) ? hi : ((v < lo) ? lo : v);
      n  = r[W-1:0];
      return OUT_W'(n);
   endfunction

   state_type               state_ff, state_in;
   logic signed [W-1:0]     sloc_ff [3], sloc_in [3];
   logic signed [W-1:0]     eloc_ff [3], eloc_in [3];
   logic signed [DIR_W-1:0] sdir_ff [3], sdir_in [3];
   logic signed [DIR_W-1:0] edir_ff [3], edir_in [3];
   logic [T_W-1:0]          t_ff, t_in;
   logic [1:0]              axis_ff, axis_in;
   logic [2:0]              step_ff, step_in;
   logic                    phase_ff, phase_in;
   logic [2*MW-1:0]         sq_ff, sq_in;
   logic [SW-1:0]           sum_ff, sum_in;
   logic [SW-1:0]           src_ff, src_in;
   logic [RW:0]             rem_ff, rem_in;
   logic [RW-1:0]           root_ff, root_in;
   logic [ITW-1:0]          iter_ff, iter_in;
   logic [HW-1:0]           h_ff, h_in;
   logic signed [IW-1:0]    ctl_ff [4], ctl_in [4];
   logic signed [PRW-1:0]   prod_ff, prod_in;
   logic signed [IW-1:0]    base_ff, base_in;
   logic [OUT_W-1:0]        pt_ff [3], pt_in [3];
   logic [OUT_W-1:0]        sl_ff [3], sl_in [3];
   logic                    valid_ff, valid_in;

   logic signed [W:0]       dval;
   logic [W:0]              dmag;
   logic [MW-1:0]           m;
   logic [RW+2:0]           rem_t;
   logic [RW+2:0]           trial;
   logic [LW-1:0]           lval;
   logic [1:0]              j;
   logic signed [DW-1:0]    diff;
   logic signed [DW-1:0]    qdiff;
   logic signed [SATW-1:0]  slope3;
   logic signed [DIR_W:0]   hdir;
   logic signed [HW:0]      hlen;
   logic signed [HPW-1:0]   hprod;
   logic signed [T_W:0]     tval;
   logic signed [LPW-1:0]   lprod;
   logic [PRW-1:0]          pmag;
   logic [PRW-1:0]          rmag;
   logic signed [PRW-1:0]   rval;
   logic signed [IW-1:0]    val;

   always_comb begin
      state_in = state_ff;
      sloc_in  = sloc_ff;
      eloc_in  = eloc_ff;
      sdir_in  = sdir_ff;
      edir_in  = edir_ff;
      t_in     = t_ff;
      axis_in  = axis_ff;
      step_in  = step_ff;
      phase_in = phase_ff;
      sq_in    = sq_ff;
      sum_in   = sum_ff;
      src_in   = src_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      iter_in  = iter_ff;
      h_in     = h_ff;
      ctl_in   = ctl_ff;
      prod_in  = prod_ff;
      base_in  = base_ff;
      pt_in    = pt_ff;
      sl_in    = sl_ff;
      valid_in = 1'b0;
      pop      = 1'b0;

      // chord component magnitude, reduced to keep the square in range
      dval = (W+1)'(eloc_ff[axis_ff]) - (W+1)'(sloc_ff[axis_ff]);
      dmag = dval[W] ? (W+1)'(-dval) : (W+1)'(dval);
      m    = MW'(dmag >> S);

      rem_t = {rem_ff, src_ff[SW-1:SW-2]};
      trial = {1'b0, root_ff, 2'b01};
      lval  = LW'(root_ff) << S;

      j      = lerp_idx(step_ff);
      diff   = DW'(ctl_ff[j + 2'd1]) - DW'(ctl_ff[j]);
      qdiff  = DW'(ctl_ff[1]) - DW'(ctl_ff[0]);
      slope3 = (SATW'(qdiff) <<< 1) + SATW'(qdiff);

      // handle offset product (start direction, or negated end direction)
      hdir  = (step_ff == 3'd0) ? (DIR_W+1)'(sdir_ff[axis_ff])
                                : -((DIR_W+1)'(edir_ff[axis_ff]));
      hlen  = signed'({1'b0, h_ff});
      hprod = HPW'(hdir) * HPW'(hlen);
      // lerp product at full width
      tval  = signed'({1'b0, t_ff});
      lprod = LPW'(diff) * LPW'(tval);

      // round half away from zero on the registered product
      pmag = prod_ff[PRW-1] ? PRW'(-prod_ff) : PRW'(prod_ff);
      if (step_ff <= STEP_P2) begin
         rmag = (pmag + HALF_DIR) >> DIR_FRAC;
      end else begin
         rmag = (pmag + HALF_T) >> T_FRAC;
      end
      rval = prod_ff[PRW-1] ? -signed'(rmag) : signed'(rmag);
      val  = base_ff + IW'(rval);

      case (state_ff)
         ST_IDLE: begin
            if (!qstat.empty) begin
               pop = 1'b1;
               case (pop_item.cmd)
                  CMD_LOAD_START: begin
                     for (int i = 0; i < 3; i++) begin
                        sloc_in[i] = pop_item.pos[i][W-1:0];
                        sdir_in[i] = pop_item.dir[i];
                     end
                  end
                  CMD_LOAD_END: begin
                     for (int i = 0; i < 3; i++) begin
                        eloc_in[i] = pop_item.pos[i][W-1:0];
                        edir_in[i] = pop_item.dir[i];
                     end
                  end
                  CMD_EVAL: begin
                     t_in     = pop_item.t;
                     axis_in  = '0;
                     phase_in = 1'b0;
                     sum_in   = '0;
                     state_in = ST_SQUARE;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SQUARE: begin
            if (!phase_ff) begin
               sq_in    = {{MW{1'b0}}, m} * {{MW{1'b0}}, m};
               phase_in = 1'b1;
            end else begin
               sum_in   = sum_ff + SW'(sq_ff);
               phase_in = 1'b0;
               if (axis_ff == 2'd2) begin
                  src_in   = sum_ff + SW'(sq_ff);
                  rem_in   = '0;
                  root_in  = '0;
                  iter_in  = '0;
                  state_in = ST_ROOT;
               end else begin
                  axis_in = axis_ff + 2'd1;
               end
            end
         end
         ST_ROOT: begin
            // one root bit per cycle
            if (rem_t >= trial) begin
               rem_in  = (RW+1)'(rem_t - trial);
               root_in = {root_ff[RW-2:0], 1'b1};
            end else begin
               rem_in  = (RW+1)'(rem_t);
               root_in = {root_ff[RW-2:0], 1'b0};
            end
            src_in  = src_ff << 2;
            iter_in = iter_ff + 1'b1;
            if (iter_ff == ITW'(RW - 1)) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            h_in     = HW'((lval + LW'(2)) >> 2);
            axis_in  = '0;
            step_in  = '0;
            phase_in = 1'b0;
            state_in = ST_CURVE;
         end
         ST_CURVE: begin
            if (!phase_ff) begin
               phase_in = 1'b1;
               case (step_ff)
                  3'd0: begin
                     ctl_in[0] = IW'(sloc_ff[axis_ff]);
                     ctl_in[3] = IW'(eloc_ff[axis_ff]);
                     base_in   = IW'(sloc_ff[axis_ff]);
                     prod_in   = PRW'(hprod);
                  end
                  3'd1: begin
                     base_in = IW'(eloc_ff[axis_ff]);
                     prod_in = PRW'(hprod);
                  end
                  default: begin
                     base_in = ctl_ff[j];
                     prod_in = PRW'(lprod);
                     if (step_ff == STEP_LAST) begin
                        sl_in[axis_ff] = sat_out(slope3);
                     end
                  end
               endcase
            end else begin
               phase_in = 1'b0;
               case (step_ff)
                  3'd0:    ctl_in[1] = val;
                  3'd1:    ctl_in[2] = val;
                  default: ctl_in[j] = val;
               endcase
               if (step_ff == STEP_LAST) begin
                  pt_in[axis_ff] = sat_out(SATW'(val));
                  step_in        = '0;
                  if (axis_ff == 2'd2) begin
                     valid_in = 1'b1;
                     state_in = ST_IDLE;
                  end else begin
                     axis_in = axis_ff + 2'd1;
                  end
               end else begin
                  step_in = step_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
         axis_ff  <= '0;
         step_ff  <= '0;
         phase_ff <= 1'b0;
         iter_ff  <= '0;
         for (int i = 0; i < 3; i++) begin
            sloc_ff[i] <= '0;
            eloc_ff[i] <= '0;
            sdir_ff[i] <= '0;
            edir_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         axis_ff  <= axis_in;
         step_ff  <= step_in;
         phase_ff <= phase_in;
         iter_ff  <= iter_in;
         sloc_ff  <= sloc_in;
         eloc_ff  <= eloc_in;
         sdir_ff  <= sdir_in;
         edir_ff  <= edir_in;
      end
   end

   always_ff @(posedge clock) begin
      t_ff    <= t_in;
      sq_ff   <= sq_in;
      sum_ff  <= sum_in;
      src_ff  <= src_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      h_ff    <= h_in;
      ctl_ff  <= ctl_in;
      prod_ff <= prod_in;
      base_ff <= base_in;
      pt_ff   <= pt_in;
      sl_ff   <= sl_in;
   end

   assign out_valid = valid_ff;
   assign out_point = pt_ff;
   assign out_slope = sl_ff;

   `ASSERT_NEXT(a_strobe_single, clock, reset, valid_ff, !valid_ff)
   `ASSERT_NEVER(a_strobe_idle, clock, reset, valid_ff && (state_ff != ST_IDLE))

endmodule

@@ sv/cubic_bezier_tangent_eval_core.sv @@
// Cubic Bezier tangent-curve evaluator.
//
// Command channel: a transfer happens on a rising edge with start high and
// busy low. Command 0 loads the start tangent point (location + direction),
// command 1 loads the end point, command 2 evaluates at req_curve_t (values
// above 1.0 clamp to 1.0). Code 3 is taken and dropped.
// Commands land in a two-entry queue; busy is high only while it is full.
// The back end pops one command at a time. A load gives no result. An
// evaluate runs in order: the chord squares, the bit-serial square root
// (one root bit a cycle), scaling of the handle length, and for each axis
// the two handle offsets and six de Casteljau lerps on one multiplier pair.
// The result on rsp_point_* and rsp_slope_* is flagged by rsp_valid for
// exactly one cycle; the receiver cannot hold it off, so take it then.
// Reset clears both tangent points to zero, empties the queue and drops any
// evaluation in flight.
module cubic_bezier_tangent_eval_core
   import cbte_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [1:0]              req_command,
   input  logic signed [POS_W-1:0] req_pos_x,
   input  logic signed [POS_W-1:0] req_pos_y,
   input  logic signed [POS_W-1:0] req_pos_z,
   input  logic signed [DIR_W-1:0] req_dir_x,
   input  logic signed [DIR_W-1:0] req_dir_y,
   input  logic signed [DIR_W-1:0] req_dir_z,
   input  logic [T_W-1:0]          req_curve_t,
   output logic                    rsp_valid,
   output logic signed [OUT_W-1:0] rsp_point_x,
   output logic signed [OUT_W-1:0] rsp_point_y,
   output logic signed [OUT_W-1:0] rsp_point_z,
   output logic signed [OUT_W-1:0] rsp_slope_x,
   output logic signed [OUT_W-1:0] rsp_slope_y,
   output logic signed [OUT_W-1:0] rsp_slope_z
);

   qstat_type        qstat;
   logic             push;
   logic             pop;
   work_type         push_item;
   work_type         pop_item;
   logic [OUT_W-1:0] point [3];
   logic [OUT_W-1:0] slope [3];

   // decode, wrap and clamp the incoming transfer
   cbte_front #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_front (
      .start       (start),
      .busy        (busy),
      .req_command (req_command),
      .req_pos_x   (req_pos_x),
      .req_pos_y   (req_pos_y),
      .req_pos_z   (req_pos_z),
      .req_dir_x   (req_dir_x),
      .req_dir_y   (req_dir_y),
      .req_dir_z   (req_dir_z),
      .req_curve_t (req_curve_t),
      .qstat       (qstat),
      .push        (push),
      .push_item   (push_item)
   );

   // hold commands between front and back
   cbte_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .qstat     (qstat)
   );

   // execute loads and evaluations
   cbte_back #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .qstat     (qstat),
      .pop_item  (pop_item),
      .pop       (pop),
      .out_valid (rsp_valid),
      .out_point (point),
      .out_slope (slope)
   );

   assign rsp_point_x = point[0];
   assign rsp_point_y = point[1];
   assign rsp_point_z = point[2];
   assign rsp_slope_x = slope[0];
   assign rsp_slope_y = slope[1];
   assign rsp_slope_z = slope[2];

endmodule
